[sv/tem_pkg.sv]
// Shared types, constants and helper functions for the text extent measurer.
// Used by tem_ctrl, tem_dp and text_extent_measure_top; depends on nothing.
package tem_pkg;

    localparam int GLYPH_CODES = 128;
    localparam int GLYPH_AW    = $clog2(GLYPH_CODES);
    localparam int FRAC_BITS   = 4;

    localparam int LINE_W  = 26;
    localparam int TOTAL_W = 24;
    localparam int WIDE_W  = 42;
    localparam int QUOT_W  = LINE_W - FRAC_BITS;
    localparam int DIVS_W  = 16 - FRAC_BITS;
    localparam int CNT_W   = $clog2(QUOT_W + 1);

    localparam logic [7:0] CODE_NUL   = 8'd0;
    localparam logic [7:0] CODE_TAB   = 8'd9;
    localparam logic [7:0] CODE_NL    = 8'd10;
    localparam logic [7:0] CODE_SPACE = 8'd32;
    localparam logic [7:0] CODE_HIGH  = 8'd128;

    localparam logic [2:0] REG_KERNING     = 3'd0;
    localparam logic [2:0] REG_LEADING     = 3'd1;
    localparam logic [2:0] REG_SPACE_WIDTH = 3'd2;
    localparam logic [2:0] REG_TAB_WIDTH   = 3'd3;
    localparam logic [2:0] REG_CHAR_HEIGHT = 3'd4;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START_SKIP,
        OP_START_GLYPH,
        OP_SPACE,
        OP_NEWLINE,
        OP_GLYPH,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_MUL,
        OP_CMP,
        OP_TAB_DONE,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   measured;
    } tem_cmd_t;

    typedef struct packed {
        logic div_last;
    } tem_stat_t;

    // Clamps a wide signed sum to the signed line width range.
    function automatic logic signed [LINE_W-1:0] clamp_line(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] lo;
        logic signed [WIDE_W-1:0] hi;
        lo = -(WIDE_W'(1) <<< (LINE_W - 1));
        hi = (WIDE_W'(1) <<< (LINE_W - 1)) - WIDE_W'(1);
        if (v < lo)
            return lo[LINE_W-1:0];
        else if (v > hi)
            return hi[LINE_W-1:0];
        else
            return v[LINE_W-1:0];
    endfunction

    // Clamps a wide signed value to the unsigned 24-bit total range.
    function automatic logic [TOTAL_W-1:0] clamp_total(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        hi = (WIDE_W'(1) <<< TOTAL_W) - WIDE_W'(1);
        if (v < 0)
            return '0;
        else if (v > hi)
            return '1;
        else
            return v[TOTAL_W-1:0];
    endfunction

endpackage

[sv/tem_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used for the glyph width table; depends on nothing.
module tem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/tem_ctrl.sv]
// Controller state machine of the text extent measurer: input and output handshakes,
// string flags and the command sequence for the datapath. Depends on tem_pkg.
module tem_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                in_cmd,
    input  logic [7:0]          in_code,
    input  logic                in_eot,
    output logic                m_tvalid,
    input  logic                m_tready,
    output tem_pkg::tem_cmd_t   dp_cmd,
    input  tem_pkg::tem_stat_t  dp_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_MUL,
        S_CMP,
        S_TAB_END,
        S_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic [7:0] code_reg, code_next;
    logic       eot_reg, eot_next;
    logic       in_string_reg, in_string_next;
    logic       skip_reg, skip_next;
    logic       ended_reg, ended_next;
    logic       out_valid_reg, out_valid_next;
    state_t     after_char;

    assign s_tready   = (state_reg == S_IDLE);
    assign m_tvalid   = out_valid_reg;
    assign after_char = eot_reg ? S_FINISH : S_IDLE;

    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        eot_next       = eot_reg;
        in_string_next = in_string_reg;
        skip_next      = skip_reg;
        ended_next     = ended_reg;
        out_valid_next = out_valid_reg;
        dp_cmd.op       = tem_pkg::OP_NONE;
        dp_cmd.measured = !skip_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                // Loads are written to the table by the top level in the accept cycle.
                if (s_tvalid && in_cmd)
                begin
                    code_next  = in_code;
                    eot_next   = in_eot;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = after_char;
                if (!in_string_reg)
                begin
                    in_string_next = 1'b1;
                    ended_next     = 1'b0;
                    if (code_reg <= tem_pkg::CODE_SPACE || code_reg >= tem_pkg::CODE_HIGH)
                    begin
                        skip_next = 1'b1;
                        dp_cmd.op = tem_pkg::OP_START_SKIP;
                    end
                    else
                    begin
                        skip_next = 1'b0;
                        dp_cmd.op = tem_pkg::OP_START_GLYPH;
                    end
                end
                else if (!skip_reg && !ended_reg)
                begin
                    if (code_reg == tem_pkg::CODE_NUL || code_reg >= tem_pkg::CODE_HIGH)
                    begin
                        ended_next = 1'b1;
                    end
                    else if (code_reg == tem_pkg::CODE_TAB)
                    begin
                        dp_cmd.op  = tem_pkg::OP_DIV_START;
                        state_next = S_DIV;
                    end
                    else if (code_reg == tem_pkg::CODE_SPACE)
                    begin
                        dp_cmd.op = tem_pkg::OP_SPACE;
                    end
                    else if (code_reg == tem_pkg::CODE_NL)
                    begin
                        dp_cmd.op = tem_pkg::OP_NEWLINE;
                    end
                    else
                    begin
                        dp_cmd.op = tem_pkg::OP_GLYPH;
                    end
                end
            end
            S_DIV:
            begin
                dp_cmd.op = tem_pkg::OP_DIV_STEP;
                if (dp_stat.div_last)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                dp_cmd.op  = tem_pkg::OP_MUL;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                dp_cmd.op  = tem_pkg::OP_CMP;
                state_next = S_TAB_END;
            end
            S_TAB_END:
            begin
                dp_cmd.op  = tem_pkg::OP_TAB_DONE;
                state_next = after_char;
            end
            S_FINISH:
            begin
                // The result register is loaded once the previous result has left.
                if (!out_valid_reg || m_tready)
                begin
                    dp_cmd.op      = tem_pkg::OP_RESULT;
                    out_valid_next = 1'b1;
                    in_string_next = 1'b0;
                    skip_next      = 1'b0;
                    ended_next     = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            code_reg      <= '0;
            eot_reg       <= 1'b0;
            in_string_reg <= 1'b0;
            skip_reg      <= 1'b0;
            ended_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            code_reg      <= code_next;
            eot_reg       <= eot_next;
            in_string_reg <= in_string_next;
            skip_reg      <= skip_next;
            ended_reg     <= ended_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[sv/tem_dp.sv]
// Datapath of the text extent measurer: line, widest line and height accumulators,
// the iterative tab stop divider, multiplier and the result register. Depends on tem_pkg.
module tem_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tem_pkg::tem_cmd_t           dp_cmd,
    output tem_pkg::tem_stat_t          dp_stat,
    input  logic [15:0]                 glyph_w,
    input  logic signed [12:0]          kerning,
    input  logic signed [12:0]          leading,
    input  logic [11:0]                 space_width,
    input  logic [15:0]                 tab_width,
    input  logic [15:0]                 char_height,
    output logic [47:0]                 m_tdata,
    output logic                        m_tuser
);

    localparam int LW = tem_pkg::LINE_W;
    localparam int WW = tem_pkg::WIDE_W;
    localparam int TW = tem_pkg::TOTAL_W;
    localparam int QW = tem_pkg::QUOT_W;
    localparam int DW = tem_pkg::DIVS_W;
    localparam int CW = tem_pkg::CNT_W;
    localparam int PW = QW + 2 + 17;

    logic signed [LW-1:0] line_reg, line_next;
    logic [TW-1:0]        widest_reg, widest_next;
    logic [TW-1:0]        total_reg, total_next;
    logic [QW-1:0]        dvd_reg, dvd_next;
    logic [DW-1:0]        rem_reg, rem_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic                 adj_reg, adj_next;
    logic [TW-1:0]        width_out_reg, width_out_next;
    logic [TW-1:0]        height_out_reg, height_out_next;
    logic                 measured_reg, measured_next;

    logic signed [WW-1:0] line_x;
    logic signed [WW-1:0] kern_x;
    logic [LW-1:0]        line_mag;
    logic [DW-1:0]        divisor;
    logic [DW:0]          trial;
    logic                 trial_ge;
    logic signed [QW+1:0] quot_s;
    logic signed [QW+1:0] quot_p1;
    logic signed [WW-1:0] prod_x;
    logic signed [WW-1:0] space_x;
    logic [TW-1:0]        line_fold;
    logic [TW-1:0]        widest_fold;

    assign line_x   = WW'(line_reg);
    assign kern_x   = WW'(kerning);
    assign space_x  = $signed({{(WW-12){1'b0}}, space_width});
    assign prod_x   = WW'(prod_reg);
    assign line_mag = line_reg[LW-1] ? LW'(-line_reg) : LW'(line_reg);
    // Whole pixels of the tab width, never below one.
    assign divisor  = (tab_width[15:tem_pkg::FRAC_BITS] == '0) ? DW'(1)
                                                               : tab_width[15:tem_pkg::FRAC_BITS];
    assign trial    = {rem_reg, dvd_reg[QW-1]};
    assign trial_ge = (trial >= {1'b0, divisor});
    assign quot_s   = neg_reg ? -$signed({2'b00, dvd_reg}) : $signed({2'b00, dvd_reg});
    assign quot_p1  = quot_s + (QW+2)'(1);
    assign line_fold   = tem_pkg::clamp_total(line_x);
    assign widest_fold = (line_fold > widest_reg) ? line_fold : widest_reg;

    assign dp_stat.div_last = (cnt_reg == CW'(1));
    assign m_tdata = {height_out_reg, width_out_reg};
    assign m_tuser = measured_reg;

    always_comb
    begin
        line_next       = line_reg;
        widest_next     = widest_reg;
        total_next      = total_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        neg_next        = neg_reg;
        prod_next       = prod_reg;
        adj_next        = adj_reg;
        width_out_next  = width_out_reg;
        height_out_next = height_out_reg;
        measured_next   = measured_reg;

        case (dp_cmd.op)
            tem_pkg::OP_START_SKIP:
            begin
                line_next   = '0;
                widest_next = '0;
                total_next  = '0;
            end
            tem_pkg::OP_START_GLYPH:
            begin
                // Starting at minus kerning and adding glyph plus kerning leaves the glyph.
                line_next   = LW'(glyph_w);
                widest_next = '0;
                total_next  = TW'(char_height);
            end
            tem_pkg::OP_SPACE:
            begin
                line_next = tem_pkg::clamp_line(line_x + space_x);
            end
            tem_pkg::OP_NEWLINE:
            begin
                widest_next = widest_fold;
                line_next   = LW'(-kern_x);
                total_next  = tem_pkg::clamp_total($signed({{(WW-TW){1'b0}}, total_reg})
                              + $signed({{(WW-16){1'b0}}, char_height}) + WW'(leading));
            end
            tem_pkg::OP_GLYPH:
            begin
                line_next = tem_pkg::clamp_line(line_x + $signed({{(WW-16){1'b0}}, glyph_w})
                                                + kern_x);
            end
            tem_pkg::OP_DIV_START:
            begin
                dvd_next = line_mag[LW-1:tem_pkg::FRAC_BITS];
                rem_next = '0;
                cnt_next = CW'(QW);
                neg_next = line_reg[LW-1];
            end
            tem_pkg::OP_DIV_STEP:
            begin
                // Restoring division, one quotient bit per cycle.
                rem_next = trial_ge ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
                dvd_next = {dvd_reg[QW-2:0], trial_ge};
                cnt_next = cnt_reg - CW'(1);
            end
            tem_pkg::OP_MUL:
            begin
                prod_next = PW'(quot_p1 * $signed({1'b0, tab_width}));
            end
            tem_pkg::OP_CMP:
            begin
                adj_next = ((prod_x - line_x) < space_x);
            end
            tem_pkg::OP_TAB_DONE:
            begin
                line_next = tem_pkg::clamp_line(prod_x + (adj_reg ? space_x : WW'(0)));
            end
            tem_pkg::OP_RESULT:
            begin
                width_out_next  = widest_fold;
                height_out_next = total_reg;
                measured_next   = dp_cmd.measured;
            end
            default:
            begin
                line_next = line_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg   <= '0;
            widest_reg <= '0;
            total_reg  <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            line_reg   <= line_next;
            widest_reg <= widest_next;
            total_reg  <= total_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        neg_reg        <= neg_next;
        prod_reg       <= prod_next;
        adj_reg        <= adj_next;
        width_out_reg  <= width_out_next;
        height_out_reg <= height_out_next;
        measured_reg   <= measured_next;
    end

endmodule

[sv/text_extent_measure_top.sv]
// Top level of the text extent measurer: configuration registers, glyph width table
// and the controller and datapath. Depends on tem_pkg, tem_ram, tem_ctrl and tem_dp.
//
// Input stream: s_tuser is the command (0 loads a glyph width, 1 is a character),
// s_tdata carries the character code or table index and the glyph width, and s_tlast
// marks the final character of a string. Each final character produces one result
// transaction on the output stream: widest line and total height in Q.4 pixels on
// m_tdata, and on m_tuser whether the string was measured.
// A load is written to the table as it is accepted. An ordinary character is accepted,
// then decoded in the execute state (the table read is registered). A tab runs the
// accept and decode steps, the restoring divider that yields one quotient bit per
// cycle for the 22-bit tab stop quotient, then a multiply, a compare and the final
// add. The final character then passes through the finish state, which loads the result register.
// The result register stays loaded until the receiver takes it; input keeps being
// accepted meanwhile, and only a following final character waits for it.
// Reset sets the configuration registers to their defaults, clears every table entry
// to zero width through per-entry valid bits and leaves the block waiting for a string.
// Configuration sits on an APB port, one 32-bit register per word.
module text_extent_measure_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // char_code [7:0], glyph_width [23:8]
    input  logic        s_tlast,
    input  logic        s_tuser,   // cmd [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // text_width [23:0], text_height [47:24]
    output logic        m_tuser,   // measured [0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = tem_pkg::GLYPH_AW;

    logic signed [12:0] kerning_reg;
    logic signed [12:0] leading_reg;
    logic [11:0]        space_width_reg;
    logic [15:0]        tab_width_reg;
    logic [15:0]        char_height_reg;

    logic [tem_pkg::GLYPH_CODES-1:0] glyph_vld_reg;
    logic                            glyph_hit_reg;

    logic               cfg_wr;
    logic [2:0]         cfg_idx;
    logic               in_accept;
    logic               tbl_we;
    logic [AW-1:0]      tbl_addr;
    logic [15:0]        tbl_rdata;
    logic [15:0]        glyph_w;
    tem_pkg::tem_cmd_t  dp_cmd;
    tem_pkg::tem_stat_t dp_stat;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kerning_reg     <= 13'sd16;
            leading_reg     <= 13'sd16;
            space_width_reg <= 12'd96;
            tab_width_reg   <= 16'd384;
            char_height_reg <= 16'd256;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                tem_pkg::REG_KERNING:     kerning_reg     <= $signed(pwdata[12:0]);
                tem_pkg::REG_LEADING:     leading_reg     <= $signed(pwdata[12:0]);
                tem_pkg::REG_SPACE_WIDTH: space_width_reg <= pwdata[11:0];
                tem_pkg::REG_TAB_WIDTH:   tab_width_reg   <= pwdata[15:0];
                tem_pkg::REG_CHAR_HEIGHT: char_height_reg <= pwdata[15:0];
                default:                  kerning_reg     <= kerning_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            tem_pkg::REG_KERNING:     prdata = {19'd0, kerning_reg};
            tem_pkg::REG_LEADING:     prdata = {19'd0, leading_reg};
            tem_pkg::REG_SPACE_WIDTH: prdata = {20'd0, space_width_reg};
            tem_pkg::REG_TAB_WIDTH:   prdata = {16'd0, tab_width_reg};
            tem_pkg::REG_CHAR_HEIGHT: prdata = {16'd0, char_height_reg};
            default:                  prdata = '0;
        endcase
    end

    // Loads outside the table are dropped; entries never loaded read as zero width.
    assign in_accept = s_tvalid && s_tready;
    assign tbl_addr  = s_tdata[AW-1:0];
    assign tbl_we    = in_accept && !s_tuser && (s_tdata[7:0] < tem_pkg::GLYPH_CODES);
    assign glyph_w   = glyph_hit_reg ? tbl_rdata : 16'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_vld_reg <= '0;
            glyph_hit_reg <= 1'b0;
        end
        else
        begin
            if (tbl_we)
            begin
                glyph_vld_reg[tbl_addr] <= 1'b1;
            end
            glyph_hit_reg <= glyph_vld_reg[tbl_addr];
        end
    end

    tem_ram #(
        .WIDTH (16),
        .DEPTH (tem_pkg::GLYPH_CODES)
    ) u_glyph_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_addr),
        .wdata (s_tdata[23:8]),
        .raddr (tbl_addr),
        .rdata (tbl_rdata)
    );

    tem_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_cmd   (s_tuser),
        .in_code  (s_tdata[7:0]),
        .in_eot   (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dp_cmd   (dp_cmd),
        .dp_stat  (dp_stat)
    );

    tem_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .dp_cmd      (dp_cmd),
        .dp_stat     (dp_stat),
        .glyph_w     (glyph_w),
        .kerning     (kerning_reg),
        .leading     (leading_reg),
        .space_width (space_width_reg),
        .tab_width   (tab_width_reg),
        .char_height (char_height_reg),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule
